// ===== rtl/cpr_pkg.sv =====
// Shared constants and types of the clock page replacement block.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

   // Default sizing
   localparam int SLOTS_DEF     = 64;
   localparam int PAGE_BITS_DEF = 20;

   // Fixed field widths
   localparam int FRAME_W  = 6;
   localparam int STATUS_W = 3;

   // Request kinds
   localparam logic REQ_REFERENCE = 1'b0;
   localparam logic REQ_EVICT     = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_HIT    = 3'd0,
      ST_INSERT = 3'd1,
      ST_EVICT  = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   // One result word
   typedef struct packed {
      logic [FRAME_W-1:0] evicted_frame;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/cpr_if.sv =====
// Request and response channel interfaces of the clock page replacement block.
`timescale 1ns / 1ps
`default_nettype none

interface cpr_req_if #(
   parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
);
   import cpr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [PAGE_BITS-1:0] page_id;
   logic [FRAME_W-1:0]   frame_number;

   modport source (output valid, output req_type, output page_id, output frame_number,
                   input ready);
   modport sink   (input valid, input req_type, input page_id, input frame_number,
                   output ready);
endinterface

interface cpr_rsp_if;
   import cpr_pkg::*;

   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  evicted_frame;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output evicted_frame, output status, input ready);
   modport sink   (input valid, input evicted_frame, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/cpr_ram.sv =====
// Generic simple dual-port RAM with registered read and write-first bypass.
`timescale 1ns / 1ps
`default_nettype none

module cpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port; a same-cycle write to the read address is forwarded
   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/cpr_engine.sv =====
// Sequencer that scans, links and sweeps the slot ring held in the two RAMs.
`timescale 1ns / 1ps
`default_nettype none

module cpr_engine #(
   parameter int SLOTS     = 64,
   parameter int PAGE_BITS = 20
) (
   input  logic                                      clock,
   input  logic                                      reset,
   cpr_req_if.sink                                   req_bus,
   // result handoff to the output register
   output logic                                      done_valid,
   output cpr_pkg::rsp_type                          done_rsp,
   input  logic                                      out_free,
   // entry RAM: used, ref, page, frame
   output logic                                      ent_we,
   output logic [$clog2(SLOTS)-1:0]                  ent_waddr,
   output logic [2+PAGE_BITS+cpr_pkg::FRAME_W-1:0]   ent_wdata,
   output logic [$clog2(SLOTS)-1:0]                  ent_raddr,
   input  logic [2+PAGE_BITS+cpr_pkg::FRAME_W-1:0]   ent_rdata,
   // link RAM: next, prev
   output logic                                      lnk_we,
   output logic [$clog2(SLOTS)-1:0]                  lnk_waddr,
   output logic [2*$clog2(SLOTS)-1:0]                lnk_wdata,
   output logic [$clog2(SLOTS)-1:0]                  lnk_raddr,
   input  logic [2*$clog2(SLOTS)-1:0]                lnk_rdata
);
   import cpr_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef struct packed {
      logic                 used;
      logic                 refb;
      logic [PAGE_BITS-1:0] page;
      logic [FRAME_W-1:0]   frame;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] next_idx;
      logic [IDX_W-1:0] prev_idx;
   } link_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_INS_HAND,
      S_INS_BEFORE,
      S_INS_PATCH,
      S_EV_TEST,
      S_EV_PREV,
      S_EV_NEXT,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     free_ff, free_in;
   logic                 free_found_ff, free_found_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]     aux_ff, aux_in;
   logic [IDX_W-1:0]     nxt_ff, nxt_in;
   rsp_type              res_ff, res_in;

   entry_type ent_rd, ent_wr;
   link_type  lnk_rd, lnk_wr;
   logic      scan_last, clr_last, hit, have_free;
   logic [IDX_W-1:0] slot_sel;

   assign ent_rd    = entry_type'(ent_rdata);
   assign lnk_rd    = link_type'(lnk_rdata);
   assign ent_wdata = ent_wr;
   assign lnk_wdata = lnk_wr;

   assign scan_last = (scan_ff == IDX_W'(SLOTS - 1));
   assign clr_last  = (clr_ff == IDX_W'(SLOTS - 1));
   assign hit       = ent_rd.used && (ent_rd.page == page_ff);
   assign have_free = free_found_ff || !ent_rd.used;
   assign slot_sel  = free_found_ff ? free_ff : scan_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign done_valid    = (state_ff == S_RESP) && out_free;
   assign done_rsp      = res_ff;

   // next-state and RAM port logic
   always_comb begin
      state_in      = state_ff;
      hand_in       = hand_ff;
      occ_in        = occ_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      page_in       = page_ff;
      frame_in      = frame_ff;
      cur_in        = cur_ff;
      aux_in        = aux_ff;
      nxt_in        = nxt_ff;
      res_in        = res_ff;

      ent_we    = 1'b0;
      ent_waddr = '0;
      ent_wr    = '0;
      ent_raddr = '0;
      lnk_we    = 1'b0;
      lnk_waddr = '0;
      lnk_wr    = '0;
      lnk_raddr = '0;

      unique case (state_ff)
         // clear used and ref bits of every slot after reset
         S_CLEAR: begin
            ent_we    = 1'b1;
            ent_waddr = clr_ff;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_bus.valid) begin
               page_in  = req_bus.page_id;
               frame_in = req_bus.frame_number;
               if (req_bus.req_type == REQ_EVICT) begin
                  if (occ_ff == '0) begin
                     res_in   = '{evicted_frame: '0, status: ST_EMPTY};
                     state_in = S_RESP;
                  end else begin
                     cur_in    = hand_ff;
                     ent_raddr = hand_ff;
                     lnk_raddr = hand_ff;
                     state_in  = S_EV_TEST;
                  end
               end else begin
                  scan_in       = '0;
                  free_found_in = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end

         // one slot per cycle: look for the page, note the lowest free slot
         S_SCAN: begin
            ent_raddr = scan_last ? '0 : scan_ff + IDX_W'(1);
            if (hit) begin
               ent_we      = 1'b1;
               ent_waddr   = scan_ff;
               ent_wr      = ent_rd;
               ent_wr.refb = 1'b1;
               res_in      = '{evicted_frame: '0, status: ST_HIT};
               state_in    = S_RESP;
            end else if (scan_last) begin
               if (!have_free) begin
                  res_in   = '{evicted_frame: '0, status: ST_FULL};
                  state_in = S_RESP;
               end else begin
                  free_in   = slot_sel;
                  ent_we    = 1'b1;
                  ent_waddr = slot_sel;
                  ent_wr    = '{used: 1'b1, refb: 1'b1, page: page_ff, frame: frame_ff};
                  if (occ_ff == '0) begin
                     // ring of one
                     lnk_we    = 1'b1;
                     lnk_waddr = slot_sel;
                     lnk_wr    = '{next_idx: slot_sel, prev_idx: slot_sel};
                     hand_in   = slot_sel;
                     occ_in    = occ_ff + CNT_W'(1);
                     res_in    = '{evicted_frame: '0, status: ST_INSERT};
                     state_in  = S_RESP;
                  end else begin
                     lnk_raddr = hand_ff;
                     state_in  = S_INS_HAND;
                  end
               end
            end else begin
               scan_in = scan_ff + IDX_W'(1);
               if (!ent_rd.used && !free_found_ff) begin
                  free_in       = scan_ff;
                  free_found_in = 1'b1;
               end
            end
         end

         // new slot goes between prev(hand) and hand
         S_INS_HAND: begin
            lnk_we    = 1'b1;
            lnk_waddr = free_ff;
            lnk_wr    = '{next_idx: hand_ff, prev_idx: lnk_rd.prev_idx};
            aux_in    = lnk_rd.prev_idx;
            lnk_raddr = lnk_rd.prev_idx;
            state_in  = S_INS_BEFORE;
         end

         S_INS_BEFORE: begin
            lnk_we    = 1'b1;
            lnk_waddr = aux_ff;
            lnk_wr    = '{next_idx: free_ff, prev_idx: lnk_rd.prev_idx};
            lnk_raddr = hand_ff;
            state_in  = S_INS_PATCH;
         end

         S_INS_PATCH: begin
            lnk_we    = 1'b1;
            lnk_waddr = hand_ff;
            lnk_wr    = '{next_idx: lnk_rd.next_idx, prev_idx: free_ff};
            occ_in    = occ_ff + CNT_W'(1);
            res_in    = '{evicted_frame: '0, status: ST_INSERT};
            state_in  = S_RESP;
         end

         // sweep: clear set ref bits until a clear one is found
         S_EV_TEST: begin
            ent_we    = 1'b1;
            ent_waddr = cur_ff;
            if (ent_rd.refb) begin
               ent_wr      = ent_rd;
               ent_wr.refb = 1'b0;
               cur_in      = lnk_rd.next_idx;
               ent_raddr   = lnk_rd.next_idx;
               lnk_raddr   = lnk_rd.next_idx;
            end else begin
               res_in    = '{evicted_frame: ent_rd.frame, status: ST_EVICT};
               aux_in    = lnk_rd.prev_idx;
               nxt_in    = lnk_rd.next_idx;
               lnk_raddr = lnk_rd.prev_idx;
               state_in  = S_EV_PREV;
            end
         end

         // unlink the victim
         S_EV_PREV: begin
            lnk_we    = 1'b1;
            lnk_waddr = aux_ff;
            lnk_wr    = '{next_idx: nxt_ff, prev_idx: lnk_rd.prev_idx};
            lnk_raddr = nxt_ff;
            state_in  = S_EV_NEXT;
         end

         S_EV_NEXT: begin
            lnk_we    = 1'b1;
            lnk_waddr = nxt_ff;
            lnk_wr    = '{next_idx: lnk_rd.next_idx, prev_idx: aux_ff};
            occ_in    = occ_ff - CNT_W'(1);
            hand_in   = (occ_ff == CNT_W'(1)) ? '0 : nxt_ff;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         hand_ff  <= '0;
         occ_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hand_ff  <= hand_in;
         occ_ff   <= occ_in;
         clr_ff   <= clr_in;
      end
      scan_ff       <= scan_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      page_ff       <= page_in;
      frame_ff      <= frame_in;
      cur_ff        <= cur_in;
      aux_ff        <= aux_in;
      nxt_ff        <= nxt_in;
      res_ff        <= res_in;
   end

endmodule

`default_nettype wire

// ===== rtl/clock_page_replacement.sv =====
// Clock (second-chance) page replacement: top level with slot RAMs and output register.
// Reference: slots are scanned in order and a hit ends the scan at the slot holding the page;
//   a miss scans all SLOTS slots; a linked insert adds S_INS_HAND, S_INS_BEFORE, S_INS_PATCH.
// Evict: sweep of set reference bits, then unlink of the victim; an empty ring skips both.
// One request at a time: the next word is taken the cycle after the result is registered.
// Reset: synchronous; then a clearing pass over every slot of the entry RAM,
//   during which no request word is taken.
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement #(
   parameter int SLOTS     = cpr_pkg::SLOTS_DEF,
   parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cpr_req_if.sink    req_bus,
   cpr_rsp_if.source  rsp_bus
);
   import cpr_pkg::*;

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int ENTRY_W = 2 + PAGE_BITS + FRAME_W;
   localparam int LINK_W  = 2 * IDX_W;

   logic               ent_we, lnk_we;
   logic [IDX_W-1:0]   ent_waddr, ent_raddr, lnk_waddr, lnk_raddr;
   logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
   logic [LINK_W-1:0]  lnk_wdata, lnk_rdata;

   logic    done_valid, out_free;
   rsp_type done_rsp;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   cpr_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   cpr_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_lnk_ram (
      .clock (clock),
      .we    (lnk_we),
      .waddr (lnk_waddr),
      .wdata (lnk_wdata),
      .raddr (lnk_raddr),
      .rdata (lnk_rdata)
   );

   cpr_engine #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .done_valid (done_valid),
      .done_rsp   (done_rsp),
      .out_free   (out_free),
      .ent_we     (ent_we),
      .ent_waddr  (ent_waddr),
      .ent_wdata  (ent_wdata),
      .ent_raddr  (ent_raddr),
      .ent_rdata  (ent_rdata),
      .lnk_we     (lnk_we),
      .lnk_waddr  (lnk_waddr),
      .lnk_wdata  (lnk_wdata),
      .lnk_raddr  (lnk_raddr),
      .lnk_rdata  (lnk_rdata)
   );

   // output register: holds a result word while the engine takes the next request
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= done_valid;
      end
      if (out_free && done_valid) begin
         rsp_data_ff <= done_rsp;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.evicted_frame = rsp_data_ff.evicted_frame;
   assign rsp_bus.status        = rsp_data_ff.status;

endmodule

`default_nettype wire

// ===== tb/sv/tb_clock_page_replacement.sv =====
// Self-checking testbench for the clock page replacement block.
`timescale 1ns / 1ps

module tb_clock_page_replacement;
   import cpr_pkg::*;

   localparam int SLOTS     = SLOTS_DEF;
   localparam int PAGE_BITS = PAGE_BITS_DEF;
   localparam int RANDOM_WORDS = 750;
   localparam int POOL_SIZE = 96;

   logic clock;
   logic reset;

   cpr_req_if #(.PAGE_BITS(PAGE_BITS)) req_bus ();
   cpr_rsp_if rsp_bus ();

   clock_page_replacement #(
      .SLOTS    (SLOTS),
      .PAGE_BITS(PAGE_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Hard stop in case the block hangs
   initial begin
      #12_000_000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Shadow copy of the ring: slot contents, links, hand, fill count
   // ---------------------------------------------------------------
   logic [PAGE_BITS-1:0] ring_page  [SLOTS];
   logic [FRAME_W-1:0]   ring_frame [SLOTS];
   bit                   ring_ref   [SLOTS];
   bit                   ring_used  [SLOTS];
   int                   ring_next  [SLOTS];
   int                   ring_prev  [SLOTS];
   int                   ring_hand;
   int                   ring_count;

   rsp_type pending_rsp [$];
   int      mismatches;
   int      words_sent;
   int      words_checked;
   int      status_count [5];
   bit      calm;
   int      sink_hold;

   function automatic void clear_ring();
      for (int s = 0; s < SLOTS; s++) begin
         ring_page[s]  = '0;
         ring_frame[s] = '0;
         ring_ref[s]   = 1'b0;
         ring_used[s]  = 1'b0;
         ring_next[s]  = 0;
         ring_prev[s]  = 0;
      end
      ring_hand  = 0;
      ring_count = 0;
   endfunction

   // Apply one request word to the shadow ring and return its reply
   function automatic rsp_type ring_apply(logic kind, logic [PAGE_BITS-1:0] page,
                                          logic [FRAME_W-1:0] frame);
      rsp_type r;
      int      slot;
      int      spare;
      int      prior;
      r.evicted_frame = '0;
      if (kind == REQ_REFERENCE) begin
         spare    = -1;
         r.status = ST_FULL;
         for (slot = 0; slot < SLOTS; slot++) begin
            if (ring_used[slot] && ring_page[slot] == page) begin
               ring_ref[slot] = 1'b1;
               r.status = ST_HIT;
               return r;
            end
            if (!ring_used[slot] && spare < 0)
               spare = slot;
         end
         if (spare >= 0 && ring_count < SLOTS) begin
            ring_used[spare]  = 1'b1;
            ring_page[spare]  = page;
            ring_frame[spare] = frame;
            ring_ref[spare]   = 1'b1;
            if (ring_count == 0) begin
               // ring of one, hand on it
               ring_next[spare] = spare;
               ring_prev[spare] = spare;
               ring_hand = spare;
            end else begin
               // link in just behind the hand
               prior = ring_prev[ring_hand];
               ring_next[spare] = ring_hand;
               ring_prev[spare] = prior;
               ring_next[prior] = spare;
               ring_prev[ring_hand] = spare;
            end
            ring_count++;
            r.status = ST_INSERT;
         end
      end else if (ring_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         // second-chance sweep: clear set bits until a clear one is found
         slot = ring_hand;
         for (int steps = 0; steps <= SLOTS && ring_ref[slot]; steps++) begin
            ring_ref[slot] = 1'b0;
            slot = ring_next[slot];
         end
         prior = ring_prev[slot];
         spare = ring_next[slot];
         ring_next[prior] = spare;
         ring_prev[spare] = prior;
         r.evicted_frame = ring_frame[slot];
         ring_used[slot] = 1'b0;
         ring_ref[slot]  = 1'b0;
         ring_count--;
         ring_hand = (ring_count == 0) ? 0 : spare;
         r.status = ST_EVICT;
      end
      return r;
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
   endfunction

   function automatic void flag_word(string why, rsp_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d (%s): expected frame %0d status %0d, got frame %0d status %0d",
                  mismatches, why, want.evicted_frame, want.status,
                  rsp_bus.evicted_frame, rsp_bus.status);
   endfunction

   // ---------------------------------------------------------------
   // Request side: drive one word, wait for it to be taken
   // ---------------------------------------------------------------
   task automatic send_word(logic kind, logic [PAGE_BITS-1:0] page, logic [FRAME_W-1:0] frame,
                            bit typed, rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = (!calm && $urandom_range(0, 4) < 2) ? idle_length() : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.req_type     = kind;
      req_bus.page_id      = page;
      req_bus.frame_number = frame;
      do
         @(posedge clock);
      while (!req_bus.ready);
      // taken at this edge
      predicted = ring_apply(kind, page, frame);
      status_count[int'(predicted.status)]++;
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Result side: random back-pressure and checking
   // ---------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      sink_hold = 0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            rsp_bus.ready = 1'b0;
            sink_hold--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               sink_hold = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_checked++;
         if (pending_rsp.size() == 0) begin
            want = '0;
            flag_word("unexpected word", want);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.evicted_frame !== want.evicted_frame || rsp_bus.status !== want.status)
               flag_word("field mismatch", want);
         end
      end
   end

   // ---------------------------------------------------------------
   // Directed rows; want is used only where typed is set
   // ---------------------------------------------------------------
   typedef struct packed {
      logic                 kind;
      logic [PAGE_BITS-1:0] page;
      logic [FRAME_W-1:0]   frame;
      bit                   typed;
      rsp_type              want;
   } step_row_type;

   step_row_type directed_steps [18] = '{
      // evict on an empty ring
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b1, '{6'd0, ST_EMPTY}},
      // first insert forms a ring of one, then hit it
      '{REQ_REFERENCE, 20'h00000, 6'd0,  1'b1, '{6'd0, ST_INSERT}},
      '{REQ_REFERENCE, 20'h00000, 6'd5,  1'b1, '{6'd0, ST_HIT}},
      '{REQ_REFERENCE, 20'hFFFFF, 6'd63, 1'b1, '{6'd0, ST_INSERT}},
      '{REQ_REFERENCE, 20'hFFFFF, 6'd0,  1'b1, '{6'd0, ST_HIT}},
      '{REQ_REFERENCE, 20'h55555, 6'd42, 1'b0, '{6'd0, ST_HIT}},
      '{REQ_REFERENCE, 20'hAAAAA, 6'd21, 1'b0, '{6'd0, ST_HIT}},
      // full sweep: every bit set
      '{REQ_EVICT,     20'hFFFFF, 6'd63, 1'b0, '{6'd0, ST_HIT}},
      '{REQ_REFERENCE, 20'h00000, 6'd1,  1'b0, '{6'd0, ST_HIT}},
      // drain down to empty, last page resets the hand
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}},
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}},
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}},
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}},
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}},
      '{REQ_REFERENCE, 20'h12345, 6'd63, 1'b0, '{6'd0, ST_HIT}},
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}},
      // refill after wrap to an empty ring
      '{REQ_REFERENCE, 20'h80000, 6'd32, 1'b0, '{6'd0, ST_HIT}},
      '{REQ_EVICT,     20'h00000, 6'd0,  1'b0, '{6'd0, ST_HIT}}
   };

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];
      logic [PAGE_BITS-1:0] page;
      int                   seg_len;
      int                   evict_pct;
      int                   random_sent;
      reset                = 1'b1;
      calm                 = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_REFERENCE;
      req_bus.page_id      = '0;
      req_bus.frame_number = '0;
      mismatches    = 0;
      words_sent    = 0;
      words_checked = 0;
      foreach (status_count[k])
         status_count[k] = 0;
      clear_ring();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, with idling
      calm = 1'b0;
      foreach (directed_steps[i])
         send_word(directed_steps[i].kind, directed_steps[i].page, directed_steps[i].frame,
                   directed_steps[i].typed, directed_steps[i].want);

      foreach (page_pool[i])
         page_pool[i] = PAGE_BITS'($urandom);
      random_sent = 0;

      // fill past capacity with fresh pages so the ring reports full
      for (int n = 0; n < SLOTS + 6; n++) begin
         send_word(REQ_REFERENCE, PAGE_BITS'($urandom), FRAME_W'($urandom), 1'b0, '0);
         random_sent++;
      end
      // drain past empty; payload fields of evict words are noise
      for (int n = 0; n < SLOTS + 6; n++) begin
         send_word(REQ_EVICT, PAGE_BITS'($urandom), FRAME_W'($urandom), 1'b0, '0);
         random_sent++;
      end

      // mixed segments over a page pool larger than the ring
      while (random_sent < RANDOM_WORDS) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: evict_pct = 10;
            1: evict_pct = 45;
            default: evict_pct = 80;
         endcase
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < seg_len; n++) begin
            if ($urandom_range(0, 99) < evict_pct) begin
               send_word(REQ_EVICT, PAGE_BITS'($urandom), FRAME_W'($urandom), 1'b0, '0);
            end else begin
               page = ($urandom_range(0, 6) == 0) ? PAGE_BITS'($urandom)
                                                  : page_pool[$urandom_range(0, POOL_SIZE - 1)];
               send_word(REQ_REFERENCE, page, FRAME_W'($urandom), 1'b0, '0);
            end
            random_sent++;
         end
      end
      req_bus.valid = 1'b0;
      calm = 1'b0;

      // let outstanding words drain, then allow one more full sweep
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (2 * SLOTS + 16) @(posedge clock);

      $display("%0d request words sent, %0d replies checked, %0d mismatches",
               words_sent, words_checked, mismatches);
      $display("replies: %0d hit, %0d insert, %0d evict, %0d empty ring, %0d ring full",
               status_count[ST_HIT], status_count[ST_INSERT], status_count[ST_EVICT],
               status_count[ST_EMPTY], status_count[ST_FULL]);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cpr_pkg.sv
rtl/cpr_if.sv
rtl/cpr_ram.sv
rtl/cpr_engine.sv
rtl/clock_page_replacement.sv
tb/sv/tb_clock_page_replacement.sv
